// File: src/tsrb_pkg.sv
// shared constants, types and weight table of the tilt-shift ring blur
package tsrb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int STORE_ROWS = 9;
    localparam int ROM_DEPTH  = 256;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = COL_W + 1;
    localparam int HGT_W  = ROW_W + 1;
    localparam int SLOT_W = $clog2(STORE_ROWS);
    localparam int IDX_W  = $clog2(ROM_DEPTH);
    localparam int PIX_W  = 8;
    localparam int WT_W   = 17;
    localparam int Z_W    = 16;
    localparam int ZREM_W = HGT_W + Z_W;
    localparam int PROD_W = PIX_W + WT_W;
    localparam int ACC_W  = 30;
    localparam int CNT_W  = 23;
    localparam int WIN    = 8;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic                take;
        logic                zdiv_init;
        logic                zdiv_step;
        logic [3:0]          zbit;
        logic                idx_en;
        logic                rom_en;
        logic                w2_en;
        logic                w3_en;
        logic                w4_en;
        logic                rd_en;
        logic [2:0]          rd_col;
        logic                cdiv_init;
        logic                cdiv_step;
        logic [2:0]          cbit;
        logic                finish;
    } tsrb_cmd_t;

    typedef struct packed {
        logic emit_req;
    } tsrb_sts_t;

    typedef logic [WT_W-1:0] weight_rom_t [ROM_DEPTH];

    // b = t^2.5 in q1.16, built at elaboration
    function automatic weight_rom_t build_weight_rom();
        weight_rom_t     rom;
        longint unsigned t;
        longint unsigned c;
        longint unsigned v;
        longint unsigned r;
        longint unsigned bt;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            t  = (longint'(i) << 16) / (ROM_DEPTH - 1);
            c  = (((t * t) >> 16) * t) >> 16;
            v  = c << 16;
            r  = 0;
            bt = 64'h4000_0000_0000_0000;
            while (bt > v)
                bt = bt >> 2;
            while (bt != 0)
            begin
                if (v >= r + bt)
                begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end
                else
                    r = r >> 1;
                bt = bt >> 2;
            end
            rom[i] = WT_W'((t * r) >> 16);
        end
        return rom;
    endfunction

    localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

// File: src/tilt_shift_ring_blur.sv
// top level of the tilt-shift ring blur
// Streaming tilt-shift blur. RGB words arrive in raster order on the slave
// side (tuser low) and are kept in nine row memories of 1024 columns; each
// output pixel is the ring-weighted truncated mean over the clipped 8x8
// window from x-4..x+3, y-4..y+3, the ring base weight growing as z^2.5 with
// the distance from the frame centre. Output (x,y) leaves once the input word
// 3w+3 pixels later is written; after the whole frame is in, words with tuser
// high flush the remaining outputs one each, and tlast marks the last output
// of the frame. A word that causes no output is taken without further steps.
// A word that causes an output runs these steps before the next word is
// taken: accept, the bit-serial centre distance divider, table index, table
// lookup and the three weight products, column reads of the row memories
// (one column of all nine rows per cycle), pipeline flush, the bit-serial
// channel divider and the load of the output register once it is free. The
// output register lets the next word be taken while a result still waits.
// Configuration writes (index 0 width, index 1 height) restart the frame and
// must be made while the block is idle; the block does not enforce this.
module tilt_shift_ring_blur (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
    input  logic        s_tuser,   // req_type: high for a drain word
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic        m_tlast    // frame_end
);
    import tsrb_pkg::*;

    tsrb_cmd_t  cmd;
    tsrb_sts_t  sts;
    logic [7:0] out_red, out_green, out_blue;

    // sequencer: accepts words, steps the datapath, owns tvalid
    tsrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: counters, line store, dividers, weighting, output word
    tsrb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (s_tuser),
        .in_red    (s_tdata[7:0]),
        .in_green  (s_tdata[15:8]),
        .in_blue   (s_tdata[23:16]),
        .cmd       (cmd),
        .sts       (sts),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .frame_end (m_tlast)
    );

    assign m_tdata = {out_blue, out_green, out_red};

endmodule

// File: src/tsrb_ctrl.sv
// sequencer of the tilt-shift ring blur
module tsrb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tsrb_pkg::tsrb_sts_t sts,
    output tsrb_pkg::tsrb_cmd_t cmd
);
    import tsrb_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ZDIV  = 11'b000_0000_0010,
        S_IDX   = 11'b000_0000_0100,
        S_ROM   = 11'b000_0000_1000,
        S_W2    = 11'b000_0001_0000,
        S_W3    = 11'b000_0010_0000,
        S_W4    = 11'b000_0100_0000,
        S_SWEEP = 11'b000_1000_0000,
        S_FLUSH = 11'b001_0000_0000,
        S_CDIV  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       ovld_reg, ovld_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovld_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + 4'd1;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                cmd.take  = in_valid;
                if (in_valid && sts.emit_req)
                begin
                    cmd.zdiv_init = 1'b1;
                    state_next    = S_ZDIV;
                end
            end
            S_ZDIV:
            begin
                cmd.zdiv_step = 1'b1;
                cmd.zbit      = 4'd15 - step_reg;
                if (step_reg == 4'd15)
                begin
                    step_next  = '0;
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                cmd.idx_en = 1'b1;
                state_next = S_ROM;
            end
            S_ROM:
            begin
                cmd.rom_en = 1'b1;
                state_next = S_W2;
            end
            S_W2:
            begin
                cmd.w2_en  = 1'b1;
                state_next = S_W3;
            end
            S_W3:
            begin
                cmd.w3_en  = 1'b1;
                state_next = S_W4;
            end
            S_W4:
            begin
                cmd.w4_en  = 1'b1;
                step_next  = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_col = step_reg[2:0];
                if (step_reg == 4'd7)
                begin
                    step_next  = '0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (step_reg == 4'd2)
                begin
                    step_next  = '0;
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (step_reg == 4'd0)
                    cmd.cdiv_init = 1'b1;
                else
                begin
                    cmd.cdiv_step = 1'b1;
                    cmd.cbit      = 3'(4'd8 - step_reg);
                end
                if (step_reg == 4'd8)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovld_next = ovld_reg;
        if (cmd.finish)
            ovld_next = 1'b1;
        else if (out_ready)
            ovld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// File: src/tsrb_dp.sv
// datapath of the tilt-shift ring blur: line store, dividers, weighting
module tsrb_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                req_type,
    input  logic [7:0]          in_red,
    input  logic [7:0]          in_green,
    input  logic [7:0]          in_blue,
    input  tsrb_pkg::tsrb_cmd_t cmd,
    output tsrb_pkg::tsrb_sts_t sts,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic                frame_end
);
    import tsrb_pkg::*;

    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;

    logic [COL_W-1:0]  wcol_reg, ecol_reg;
    logic [ROW_W-1:0]  wrow_reg, erow_reg;
    logic [SLOT_W-1:0] wslot_reg, eslot_reg;
    logic [ROW_W-1:0]  pend_reg;
    logic              fw_reg;

    logic [HGT_W-1:0]  pend_inc;
    logic [HGT_W-1:0]  thresh;
    logic              pix_take;
    logic              wlast_col, wlast_row, elast_col, elast_row;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < WID_W'(8))
            w_eff = WID_W'(8);
        else if (width_reg > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = HGT_W'(1);
        else if (height_reg > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
    end

    assign pend_inc  = {1'b0, pend_reg} + HGT_W'(1);
    assign thresh    = ({2'b0, w_eff} << 1) + {2'b0, w_eff} + HGT_W'(3);
    assign pix_take  = cmd.take && !req_type && !fw_reg;
    assign wlast_col = ({1'b0, wcol_reg} + WID_W'(1)) >= w_eff;
    assign wlast_row = ({1'b0, wrow_reg} + HGT_W'(1)) >= h_eff;
    assign elast_col = ({1'b0, ecol_reg} + WID_W'(1)) >= w_eff;
    assign elast_row = ({1'b0, erow_reg} + HGT_W'(1)) >= h_eff;

    assign sts.emit_req = (!req_type && !fw_reg && (pend_inc > thresh))
                       || (req_type && fw_reg && (pend_reg != '0));

    // position counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            wcol_reg   <= '0;
            wrow_reg   <= '0;
            wslot_reg  <= '0;
            ecol_reg   <= '0;
            erow_reg   <= '0;
            eslot_reg  <= '0;
            pend_reg   <= '0;
            fw_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
            wcol_reg  <= '0;
            wrow_reg  <= '0;
            wslot_reg <= '0;
            ecol_reg  <= '0;
            erow_reg  <= '0;
            eslot_reg <= '0;
            pend_reg  <= '0;
            fw_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (elast_col && elast_row)
            begin
                wcol_reg  <= '0;
                wrow_reg  <= '0;
                wslot_reg <= '0;
                ecol_reg  <= '0;
                erow_reg  <= '0;
                eslot_reg <= '0;
                pend_reg  <= '0;
                fw_reg    <= 1'b0;
            end
            else
            begin
                if (elast_col)
                begin
                    ecol_reg  <= '0;
                    erow_reg  <= erow_reg + ROW_W'(1);
                    eslot_reg <= (eslot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                                 : eslot_reg + SLOT_W'(1);
                end
                else
                    ecol_reg <= ecol_reg + COL_W'(1);
                if (pend_reg != '0)
                    pend_reg <= pend_reg - ROW_W'(1);
            end
        end
        else if (pix_take)
        begin
            pend_reg <= pend_inc[ROW_W-1:0];
            if (wlast_col)
            begin
                wcol_reg <= '0;
                if (wlast_row)
                    fw_reg <= 1'b1;
                else
                begin
                    wrow_reg  <= wrow_reg + ROW_W'(1);
                    wslot_reg <= (wslot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                                 : wslot_reg + SLOT_W'(1);
                end
            end
            else
                wcol_reg <= wcol_reg + COL_W'(1);
        end
    end

    // nine row memories, written one at a time, read together per column
    logic [WID_W-1:0]      colsum;
    logic                  col_ok;
    logic [COL_W-1:0]      raddr;
    logic [3*PIX_W-1:0]    rdata [STORE_ROWS];

    assign colsum = {1'b0, ecol_reg} + WID_W'(cmd.rd_col);
    assign col_ok = (colsum >= WID_W'(4)) && ((colsum - WID_W'(4)) < w_eff);
    assign raddr  = COL_W'(colsum - WID_W'(4));

    for (genvar k = 0; k < STORE_ROWS; k++)
    begin : g_row
        logic [3*PIX_W-1:0] mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (pix_take && (wslot_reg == SLOT_W'(k)))
                mem[wcol_reg] <= {in_red, in_green, in_blue};
            if (cmd.rd_en)
                rdata[k] <= mem[raddr];
        end
    end

    // centre distance divider, one quotient bit per cycle for x and y
    logic [WID_W-1:0]  cx, dx;
    logic [HGT_W-1:0]  cy, dy;
    logic [ZREM_W-1:0] zrx_reg, zry_reg;
    logic [Z_W-1:0]    zqx_reg, zqy_reg;
    logic [ZREM_W-1:0] zdx, zdy;

    assign cx  = w_eff >> 1;
    assign cy  = h_eff >> 1;
    assign dx  = ({1'b0, ecol_reg} > cx) ? {1'b0, ecol_reg} - cx : cx - {1'b0, ecol_reg};
    assign dy  = ({1'b0, erow_reg} > cy) ? {1'b0, erow_reg} - cy : cy - {1'b0, erow_reg};
    assign zdx = ZREM_W'(w_eff) << cmd.zbit;
    assign zdy = ZREM_W'(h_eff) << cmd.zbit;

    always_ff @(posedge clk)
    begin
        if (cmd.zdiv_init)
        begin
            zrx_reg <= ZREM_W'(dx) << Z_W;
            zry_reg <= ZREM_W'(dy) << Z_W;
            zqx_reg <= '0;
            zqy_reg <= '0;
        end
        else if (cmd.zdiv_step)
        begin
            if (zrx_reg >= zdx)
            begin
                zrx_reg <= zrx_reg - zdx;
                zqx_reg[cmd.zbit] <= 1'b1;
            end
            if (zry_reg >= zdy)
            begin
                zry_reg <= zry_reg - zdy;
                zqy_reg[cmd.zbit] <= 1'b1;
            end
        end
    end

    // table index and ring weights
    logic [Z_W-1:0]      zmax;
    logic [Z_W+7:0]      zscaled;
    logic [IDX_W:0]      idx_full;
    logic [IDX_W-1:0]    idx_reg;
    logic [WT_W-1:0]     b_reg, w2_reg, w3_reg, w4_reg;
    logic [2*WT_W-1:0]   wmul;
    logic [WT_W-1:0]     wmul_src;
    logic [WT_W-1:0]     wt [5];

    assign zmax     = (zqx_reg > zqy_reg) ? zqx_reg : zqy_reg;
    assign zscaled  = {zmax, 8'b0} - {8'b0, zmax};
    assign idx_full = zscaled[Z_W+7:15];
    assign wmul_src = cmd.w2_en ? b_reg : (cmd.w3_en ? w2_reg : w3_reg);
    assign wmul     = wmul_src * b_reg;
    assign wt[0]    = WT_W'(65536);
    assign wt[1]    = b_reg;
    assign wt[2]    = w2_reg;
    assign wt[3]    = w3_reg;
    assign wt[4]    = w4_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.idx_en)
            idx_reg <= (idx_full > (IDX_W+1)'(ROM_DEPTH - 1)) ? IDX_W'(ROM_DEPTH - 1)
                       : idx_full[IDX_W-1:0];
        if (cmd.rom_en)
            b_reg <= WEIGHT_ROM[idx_reg];
        if (cmd.w2_en)
            w2_reg <= wmul[WT_W+15:16];
        if (cmd.w3_en)
            w3_reg <= wmul[WT_W+15:16];
        if (cmd.w4_en)
            w4_reg <= wmul[WT_W+15:16];
    end

    // window sweep: read, weight, accumulate
    logic                  s1_vld_reg, s2_vld_reg;
    logic [2:0]            s1_j_reg;
    logic                  s1_cok_reg;
    logic [SLOT_W-1:0]     base;
    logic [WIN-1:0]        row_ok;
    logic [WT_W-1:0]       g [WIN];
    logic [3*PIX_W-1:0]    pix [WIN];
    logic [PROD_W-1:0]     pr_reg [WIN];
    logic [PROD_W-1:0]     pg_reg [WIN];
    logic [PROD_W-1:0]     pb_reg [WIN];
    logic [WT_W-1:0]       g_reg [WIN];
    logic [ACC_W-1:0]      accr_reg, accg_reg, accb_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ACC_W-1:0]      sumr, sumg, sumb;
    logic [CNT_W-1:0]      sumc;

    assign base = (eslot_reg + SLOT_W'(5) >= SLOT_W'(STORE_ROWS))
                  ? eslot_reg + SLOT_W'(5) - SLOT_W'(STORE_ROWS)
                  : eslot_reg + SLOT_W'(5);

    always_comb
    begin
        logic [HGT_W-1:0]  ysum;
        logic [SLOT_W:0]   slot;
        logic [2:0]        dr;
        logic [2:0]        dc;
        logic [2:0]        ring;
        for (int r = 0; r < WIN; r++)
        begin
            ysum      = {1'b0, erow_reg} + HGT_W'(r);
            row_ok[r] = (ysum >= HGT_W'(4)) && ((ysum - HGT_W'(4)) < h_eff);
            slot      = {1'b0, base} + (SLOT_W+1)'(r);
            if (slot >= (SLOT_W+1)'(STORE_ROWS))
                slot = slot - (SLOT_W+1)'(STORE_ROWS);
            // entries outside the frame may never have been written
            pix[r]    = (row_ok[r] && s1_cok_reg) ? rdata[SLOT_W'(slot)] : '0;
            dr        = (r >= 4) ? 3'(r - 4) : 3'(4 - r);
            dc        = (s1_j_reg >= 3'd4) ? s1_j_reg - 3'd4 : 3'd4 - s1_j_reg;
            ring      = (dr > dc) ? dr : dc;
            g[r]      = (row_ok[r] && s1_cok_reg) ? wt[ring] : '0;
        end
    end

    always_comb
    begin
        sumr = '0;
        sumg = '0;
        sumb = '0;
        sumc = '0;
        for (int r = 0; r < WIN; r++)
        begin
            sumr = sumr + ACC_W'(pr_reg[r]);
            sumg = sumg + ACC_W'(pg_reg[r]);
            sumb = sumb + ACC_W'(pb_reg[r]);
            sumc = sumc + CNT_W'(g_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.rd_en;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            s1_j_reg   <= cmd.rd_col;
            s1_cok_reg <= col_ok;
        end
        if (s1_vld_reg)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                pr_reg[r] <= pix[r][23:16] * g[r];
                pg_reg[r] <= pix[r][15:8] * g[r];
                pb_reg[r] <= pix[r][7:0] * g[r];
                g_reg[r]  <= g[r];
            end
        end
        if (cmd.zdiv_init)
        begin
            accr_reg <= '0;
            accg_reg <= '0;
            accb_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (s2_vld_reg)
        begin
            accr_reg <= accr_reg + sumr;
            accg_reg <= accg_reg + sumg;
            accb_reg <= accb_reg + sumb;
            cnt_reg  <= cnt_reg + sumc;
        end
    end

    // channel divider, one quotient bit per cycle for all three channels
    logic [ACC_W:0]   crr_reg, crg_reg, crb_reg;
    logic [PIX_W-1:0] cqr_reg, cqg_reg, cqb_reg;
    logic [ACC_W:0]   cdiv;

    assign cdiv = (ACC_W+1)'(cnt_reg) << cmd.cbit;

    always_ff @(posedge clk)
    begin
        if (cmd.cdiv_init)
        begin
            crr_reg <= {1'b0, accr_reg};
            crg_reg <= {1'b0, accg_reg};
            crb_reg <= {1'b0, accb_reg};
            cqr_reg <= '0;
            cqg_reg <= '0;
            cqb_reg <= '0;
        end
        else if (cmd.cdiv_step)
        begin
            if (crr_reg >= cdiv)
            begin
                crr_reg <= crr_reg - cdiv;
                cqr_reg[cmd.cbit] <= 1'b1;
            end
            if (crg_reg >= cdiv)
            begin
                crg_reg <= crg_reg - cdiv;
                cqg_reg[cmd.cbit] <= 1'b1;
            end
            if (crb_reg >= cdiv)
            begin
                crb_reg <= crb_reg - cdiv;
                cqb_reg[cmd.cbit] <= 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_red   <= (cnt_reg == '0) ? '0 : cqr_reg;
            out_green <= (cnt_reg == '0) ? '0 : cqg_reg;
            out_blue  <= (cnt_reg == '0) ? '0 : cqb_reg;
            frame_end <= elast_col && elast_row;
        end
    end

endmodule

// File: test/tb_tilt_shift_ring_blur.sv
// self-checking testbench of the tilt-shift ring blur
module tb_tilt_shift_ring_blur;
    import tsrb_pkg::*;

    localparam int  CLK_HALF     = 5;
    localparam int  RESET_CYCLES = 12;
    localparam int  SETTLE       = 60;       // longer than the output path of one word
    localparam int  ITEM_TARGET  = 1750;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  HOLD_CYCLES  = 400;

    typedef struct packed {
        logic       drain;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } px_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_px_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // in_red [7:0], in_green [15:8], in_blue [23:16]
    logic        s_tuser;   // drain flag
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // out_red [7:0], out_green [15:8], out_blue [23:16]
    logic        m_tlast;   // frame_end

    tilt_shift_ring_blur dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // stimulus and expectation stores
    px_word_t word_queue [$];
    blur_px_t blur_queue [$];

    int unsigned words_taken;
    int unsigned blurs_seen;
    int unsigned frames_closed;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned words_planned;
    int unsigned cfg_writes;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    bit          hold_done;

    // ------------------------------------------------------------------
    // predictor state: line store, counters, registers and weight table
    // ------------------------------------------------------------------
    logic [23:0]     store_mem [STORE_ROWS*MAX_WIDTH];
    longint unsigned base_weight [ROM_DEPTH];
    int unsigned     width_reg;
    int unsigned     height_reg;
    int unsigned     put_col, put_row, out_col, out_row, backlog;
    bit              frame_full;

    // b = t^2.5 in q1.16; square root found by bisection
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd131072;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic int unsigned used_width();
        if (width_reg < 8)
            return 8;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg < 1)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    // centre distance in q0.16, term truncated
    function automatic longint unsigned centre_dist(int unsigned p, int unsigned n);
        longint unsigned mid;
        longint unsigned d;
        mid = n / 2;
        d   = (p > mid) ? p - mid : mid - p;
        return (d << 16) / n;
    endfunction

    function automatic void restart_frame();
        put_col    = 0;
        put_row    = 0;
        out_col    = 0;
        out_row    = 0;
        backlog    = 0;
        frame_full = 0;
    endfunction

    // weighted window mean of the next output pixel, then advance
    function automatic void blur_next(int unsigned w, int unsigned h);
        longint unsigned z;
        longint unsigned zy;
        longint unsigned idx;
        longint unsigned wt [5];
        longint unsigned sr, sg, sb, wsum, g;
        int unsigned     y0, y1, x0, x1, dx, dy, ring;
        logic [23:0]     pix;
        blur_px_t        res;
        z  = centre_dist(out_col, w);
        zy = centre_dist(out_row, h);
        if (zy > z)
            z = zy;
        idx = (z * (ROM_DEPTH - 1)) >> 15;
        if (idx > ROM_DEPTH - 1)
            idx = ROM_DEPTH - 1;
        wt[0] = 65536;
        wt[1] = base_weight[idx];
        for (int k = 2; k <= 4; k++)
            wt[k] = (wt[k-1] * wt[1]) >> 16;
        y0 = (out_row >= 4) ? out_row - 4 : 0;
        y1 = (out_row + 4 < h) ? out_row + 4 : h;
        x0 = (out_col >= 4) ? out_col - 4 : 0;
        x1 = (out_col + 4 < w) ? out_col + 4 : w;
        sr = 0; sg = 0; sb = 0; wsum = 0;
        for (int unsigned yy = y0; yy < y1; yy++)
            for (int unsigned xx = x0; xx < x1; xx++)
            begin
                dy   = (yy > out_row) ? yy - out_row : out_row - yy;
                dx   = (xx > out_col) ? xx - out_col : out_col - xx;
                ring = (dx > dy) ? dx : dy;
                if (ring > 4)
                    ring = 4;
                g    = wt[ring];
                pix  = store_mem[(yy % STORE_ROWS) * MAX_WIDTH + (xx % MAX_WIDTH)];
                sr  += longint'(pix[23:16]) * g;
                sg  += longint'(pix[15:8]) * g;
                sb  += longint'(pix[7:0]) * g;
                wsum += g;
            end
        if (wsum != 0)
        begin
            res.red   = 8'(sr / wsum);
            res.green = 8'(sg / wsum);
            res.blue  = 8'(sb / wsum);
        end
        else
        begin
            res.red = 0; res.green = 0; res.blue = 0;
        end
        res.last = (out_col + 1 >= w) && (out_row + 1 >= h);
        blur_queue.push_back(res);
        if (res.last)
        begin
            restart_frame();
            return;
        end
        if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        if (backlog > 0)
            backlog--;
    endfunction

    // one accepted word through the predictor
    function automatic void absorb_word(px_word_t wd);
        int unsigned w;
        int unsigned h;
        w = used_width();
        h = used_height();
        if (wd.drain)
        begin
            if (frame_full && backlog > 0)
                blur_next(w, h);
            return;
        end
        if (frame_full)
            return;
        store_mem[(put_row % STORE_ROWS) * MAX_WIDTH + put_col] = {wd.red, wd.green, wd.blue};
        if (put_col + 1 >= w)
        begin
            put_col = 0;
            if (put_row + 1 >= h)
                frame_full = 1;
            else
                put_row++;
        end
        else
            put_col++;
        backlog++;
        if (backlog > 3 * w + 3)
            blur_next(w, h);
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever
            #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending, %0d results pending",
                     cycle_count, word_queue.size(), blur_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver: takes words from the queue, offers them on the slave side
    // ------------------------------------------------------------------
    px_word_t offered;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_word(offered);
                words_taken <= words_taken + 1;
            end
            // a new word may go out once the current one is gone
            if (!s_tvalid || s_tready)
            begin
                if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered.drain;
                    s_tdata  <= {offered.blue, offered.green, offered.red};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // idling phases follow the number of words taken
    always @(posedge clk)
    begin
        if (words_taken < ITEM_TARGET / 3)
        begin
            send_idle_pct <= 9;
            recv_idle_pct <= 76;
        end
        else if (words_taken < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct <= 76;
            recv_idle_pct <= 9;
        end
        else
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: random ready, one long hold-off, checks each result
    // ------------------------------------------------------------------
    blur_px_t seen;
    blur_px_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = '{red: m_tdata[7:0], green: m_tdata[15:8],
                         blue: m_tdata[23:16], last: m_tlast};
                blurs_seen <= blurs_seen + 1;
                if (m_tlast)
                    frames_closed <= frames_closed + 1;
                if (blur_queue.size() == 0)
                begin
                    $display("%0t: unexpected word r=%0d g=%0d b=%0d last=%0d", $time,
                             seen.red, seen.green, seen.blue, seen.last);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = blur_queue.pop_front();
                    if (seen != want)
                    begin
                        $display("%0t: mismatch expected r=%0d g=%0d b=%0d last=%0d",
                                 $time, want.red, want.green, want.blue, want.last);
                        $display("%0t:          actual   r=%0d g=%0d b=%0d last=%0d",
                                 $time, seen.red, seen.green, seen.blue, seen.last);
                        error_count <= error_count + 1;
                    end
                end
            end
            // long stall once the random part is under way, so the block backs up
            if (!hold_done && words_taken > 250 && blur_queue.size() > 0)
            begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        word_queue.push_back('{drain: 1'b0, red: r, green: g, blue: b});
        words_planned++;
    endtask

    task automatic queue_drain();
        // color bits of a drain are don't-care, so they carry noise
        word_queue.push_back('{drain: 1'b1, red: 8'($urandom), green: 8'($urandom),
                               blue: 8'($urandom)});
        words_planned++;
    endtask

    task automatic queue_random_pixels(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // block must be quiet: all words taken, all results out, pipeline empty
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (word_queue.size() > 0 || s_tvalid || blur_queue.size() > 0);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] value);
        wait_quiet();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_WIDTH)
            width_reg = value[10:0];
        else
            height_reg = value;
        restart_frame();
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // drains for the outputs still pending, plus up to two spare ones
    task automatic queue_flush(input int unsigned w, input int unsigned h);
        int unsigned tail;
        tail = (w * h < 3 * w + 3) ? w * h : 3 * w + 3;
        repeat (tail + $urandom_range(2))
            queue_drain();
    endtask

    int unsigned fw, fh, cut;

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_WIDTH;
        cfg_data    = '0;
        m_tready    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        words_taken = 0;
        blurs_seen  = 0;
        frames_closed = 0;
        error_count = 0;
        cycle_count = 0;
        words_planned = 0;
        cfg_writes  = 0;
        send_idle_pct = 9;
        recv_idle_pct = 76;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            longint unsigned t, c, s;
            t = (longint'(i) << 16) / (ROM_DEPTH - 1);
            c = (((t * t) >> 16) * t) >> 16;
            s = root_floor(c << 16);
            base_weight[i] = (t * s) >> 16;
        end
        width_reg  = 640;
        height_reg = 480;
        restart_frame();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: registers below range saturate to an 8x1 frame
        write_reg(REG_WIDTH, 13'd0);
        write_reg(REG_HEIGHT, 13'd0);
        queue_drain();                          // drain before frame is in, ignored
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hff, 8'hff, 8'hff);
        queue_pixel(8'hff, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hff, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hff);
        queue_pixel(8'haa, 8'h55, 8'hff);
        queue_pixel(8'h55, 8'haa, 8'h00);
        queue_pixel(8'hff, 8'hff, 8'hff);
        queue_pixel(8'h12, 8'h34, 8'h56);       // frame already in, ignored
        repeat (9)
            queue_drain();                      // last drain finds nothing, ignored

        // directed: registers above range saturate to the largest frame
        write_reg(REG_WIDTH, 13'h7ff);
        write_reg(REG_HEIGHT, 13'h1fff);
        queue_random_pixels(40);

        // directed: wide, tall frame, a few rows fed through so outputs flow
        write_reg(REG_WIDTH, 13'd256);
        write_reg(REG_HEIGHT, 13'd4096);
        queue_random_pixels(3 * 256 + 12);

        // random frames, mostly small, some cut short by a register write
        fw = 8;
        fh = 1;
        while (words_planned < ITEM_TARGET)
        begin
            if ($urandom_range(1) == 0 || fw == 8 && fh == 1)
            begin
                fw = ($urandom_range(7) == 0) ? $urandom_range(16, 24) : $urandom_range(8, 13);
                fh = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
                write_reg(REG_WIDTH, 13'(fw));
                write_reg(REG_HEIGHT, 13'(fh));
            end
            if ($urandom_range(7) == 0)
            begin
                cut = $urandom_range(1, fw * fh);
                queue_random_pixels(cut);
                queue_drain();
                fw = 8;                         // force a rewrite to restart
                fh = 1;
            end
            else
            begin
                for (int unsigned i = 0; i < fw * fh; i++)
                begin
                    queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                    if ($urandom_range(19) == 0)
                        queue_drain();          // early drain, ignored
                end
                if ($urandom_range(3) == 0)
                    queue_random_pixels(1);     // stray pixel, ignored
                queue_flush(fw, fh);
            end
        end

        wait_quiet();
        $display("ran %0d words through %0d register writes and small frames up to 24x12,",
                 words_taken, cfg_writes);
        $display("checked %0d blurred words and %0d frame ends with idle, stall and backpressure",
                 blurs_seen, frames_closed);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
